/* src/tfc_pkg.sv */
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types and constants for the temperature fan curve block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfc_pkg;

  // Field widths
  localparam int TEMP_W     = 18;
  localparam int DUTY_W     = 10;
  localparam int ERR_W      = 32;
  localparam int OFFSET_W   = 16;
  localparam int PCT_W      = 7;
  localparam int THR_W      = 16;
  localparam int PIDX_W     = 2;
  localparam int COUNT_W    = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  // Divider sizing: |t - lo| (16 bits) times |duty span| (10 bits)
  localparam int MAG_W      = 16;
  localparam int SPAN_W     = 10;
  localparam int PROD_W     = MAG_W + SPAN_W;
  localparam int DIV_STEPS  = PROD_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic signed [TEMP_W-1:0] VALID_FLOOR = -18'sd70000;
  localparam logic signed [TEMP_W-1:0] T_MAX       = 18'sd131071;
  localparam logic signed [TEMP_W-1:0] T_MIN       = -18'sd131072;

  localparam logic [DUTY_W-1:0] DUTY_RESET = 10'd900;
  localparam logic [DUTY_W-1:0] DUTY_MAX   = 10'd1000;
  localparam logic [PCT_W-1:0]  PCT_MAX    = 7'd100;

  // Register reset values
  localparam logic [PCT_W-1:0] LOW_PCT_RESET  = 7'd50;
  localparam logic [PCT_W-1:0] HIGH_PCT_RESET = 7'd90;
  localparam logic [THR_W-1:0] LOW_T_RESET    = 16'd25000;
  localparam logic [THR_W-1:0] HIGH_T_RESET   = 16'd35000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORCE_MAX    = 3'd0,
    REG_LOW_DUTY     = 3'd1,
    REG_HIGH_DUTY    = 3'd2,
    REG_LOW_TEMP     = 3'd3,
    REG_HIGH_TEMP    = 3'd4,
    REG_PRIMARY      = 3'd5,
    REG_SENSOR_COUNT = 3'd6,
    REG_OFFSETS      = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    ACT_READING = 1'b0,
    ACT_TICK    = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    MODE_LINEAR = 2'd0,
    MODE_HIGH   = 2'd1,
    MODE_LOW    = 2'd2
  } duty_mode_e;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic prep;
    logic div_step;
    logic commit;
  } tfc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
  } tfc_status_t;

  // Percent to per-mille, percent values above 100 treated as 100
  function automatic logic [DUTY_W-1:0] pct_to_pm(input logic [PCT_W-1:0] p);
    logic [PCT_W-1:0] c;
    c = (p > PCT_MAX) ? PCT_MAX : p;
    return DUTY_W'(c) * DUTY_W'(10);
  endfunction

endpackage

`default_nettype wire

/* src/temperature_fan_curve.sv */
// A sensor reading passes through accept, prepare and commit; a control tick
// also runs the bit-serial restoring divider between prepare and commit. No
// new transaction is accepted until the previous one has committed. Reset
// (rst, synchronous) restores every configuration register to its default,
// clears the sensor store and error count and sets the duty to 900
// per-mille.
// ----------------------------------------------------------------------------
// temperature_fan_curve
// Sensor collection and linear temperature to fan duty curve.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module temperature_fan_curve
  import tfc_pkg::*;
#(
  parameter int MAX_SENSORS = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Configuration write port
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  // Input channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     action,
  input  wire logic [PIDX_W-1:0]        sensor_index,
  input  wire logic signed [TEMP_W-1:0] reading_milli,
  input  wire logic                     read_ok,
  // Output channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [DUTY_W-1:0]             duty_permille,
  output logic                          duty_updated,
  output logic signed [TEMP_W-1:0]      primary_milli,
  output logic [ERR_W-1:0]              error_total
);

  // The controller walks each transaction through accept, prepare, divide
  // (ticks only) and commit. Commit waits only for the output register to be
  // free, so a finished result can sit there while the next transaction is
  // already being worked on.
  tfc_cmd_t    cmd;
  tfc_status_t status;

  tfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the registers, the per-sensor store, the saturating
  // error counter and the duty register. A tick clamps the primary
  // temperature, multiplies the clamped distance by the duty span and divides
  // by the threshold span bit-serially; the sign is applied afterwards so the
  // quotient truncates towards zero.
  tfc_dpath #(
    .MAX_SENSORS (MAX_SENSORS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .sensor_index  (sensor_index),
    .reading_milli (reading_milli),
    .read_ok       (read_ok),
    .cmd           (cmd),
    .status        (status),
    .duty_permille (duty_permille),
    .duty_updated  (duty_updated),
    .primary_milli (primary_milli),
    .error_total   (error_total)
  );

`ifndef NO_ASSERTIONS
  // One transaction in flight: an accepted item drops ready next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction was in flight");

  // A commit never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("output register overwritten before transfer");

  // Duty stays within per-mille range
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_permille <= DUTY_MAX))
    else $error("duty out of range");

  // A reading transaction reports no primary temperature
  a_reading_prim: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !duty_updated) |-> (primary_milli == '0))
    else $error("primary temperature reported on a reading");
`endif

endmodule

`default_nettype wire

/* src/tfc_ctrl.sv */
// ----------------------------------------------------------------------------
// tfc_ctrl
// Sequencer: accept, prepare, iterate the divider, commit to the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfc_ctrl
  import tfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  input  wire tfc_status_t status,
  output tfc_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;
  logic              slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    step_next      = step;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        step_next  = '0;
        state_next = status.is_tick ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

/* src/tfc_dpath.sv */
// ----------------------------------------------------------------------------
// tfc_dpath
// Registers, sensor store, error counter, curve arithmetic and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfc_dpath
  import tfc_pkg::*;
#(
  parameter int MAX_SENSORS = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                     action,
  input  wire logic [PIDX_W-1:0]        sensor_index,
  input  wire logic signed [TEMP_W-1:0] reading_milli,
  input  wire logic                     read_ok,
  input  wire tfc_cmd_t                 cmd,
  output tfc_status_t                   status,
  output logic [DUTY_W-1:0]             duty_permille,
  output logic                          duty_updated,
  output logic signed [TEMP_W-1:0]      primary_milli,
  output logic [ERR_W-1:0]              error_total
);

  localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_SENSORS);

  // Configuration registers
  logic                  force_max;
  logic [PCT_W-1:0]      low_duty_pct, high_duty_pct;
  logic [THR_W-1:0]      low_temp_milli, high_temp_milli;
  logic [PIDX_W-1:0]     primary_index;
  logic [COUNT_W-1:0]    num_sensors;
  logic [CFG_DATA_W-1:0] offset_table;

  // State
  logic signed [TEMP_W-1:0] temp_store [MAX_SENSORS];
  logic [ERR_W-1:0]         err_cnt;
  logic [DUTY_W-1:0]        duty_reg;

  // Latched transaction
  logic                     act_r;
  logic [PIDX_W-1:0]        idx_r;
  logic signed [TEMP_W-1:0] reading_r;
  logic                     ok_r;

  // Prepared tick operands
  logic signed [TEMP_W-1:0] prim_r;
  logic [DUTY_W-1:0]        lo_pm_r, hi_pm_r;
  logic                     neg_r;
  duty_mode_e               mode_r;
  logic [MAG_W-1:0]         den_r;
  logic [PROD_W-1:0]        quo;
  logic [MAG_W-1:0]         rem;

  assign status.is_tick = (act_r == ACT_TICK);

  // Effective sensor count
  logic [COUNT_W-1:0] cnt;
  assign cnt = (num_sensors > MAX_CNT) ? MAX_CNT : num_sensors;

  always_ff @(posedge clk) begin
    if (rst) begin
      force_max       <= 1'b0;
      low_duty_pct    <= LOW_PCT_RESET;
      high_duty_pct   <= HIGH_PCT_RESET;
      low_temp_milli  <= LOW_T_RESET;
      high_temp_milli <= HIGH_T_RESET;
      primary_index   <= '0;
      num_sensors     <= '0;
      offset_table    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_FORCE_MAX:    force_max       <= cfg_data[0];
        REG_LOW_DUTY:     low_duty_pct    <= cfg_data[PCT_W-1:0];
        REG_HIGH_DUTY:    high_duty_pct   <= cfg_data[PCT_W-1:0];
        REG_LOW_TEMP:     low_temp_milli  <= cfg_data[THR_W-1:0];
        REG_HIGH_TEMP:    high_temp_milli <= cfg_data[THR_W-1:0];
        REG_PRIMARY:      primary_index   <= cfg_data[PIDX_W-1:0];
        REG_SENSOR_COUNT: num_sensors     <= cfg_data[COUNT_W-1:0];
        REG_OFFSETS:      offset_table    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r     <= action;
      idx_r     <= sensor_index;
      reading_r <= reading_milli;
      ok_r      <= read_ok;
    end
  end

  // ---- Prepare: pick primary, clamp, form product and divisor ----
  logic [COUNT_W-1:0]       pidx_ext;
  logic [PIDX_W-1:0]        psel;
  logic signed [TEMP_W-1:0] prim;
  logic signed [TEMP_W:0]   lo_s, hi_s, t_s, dt;
  logic signed [THR_W:0]    den_s;
  logic [DUTY_W-1:0]        lo_pm, hi_pm;
  logic signed [DUTY_W:0]   span;
  logic [MAG_W-1:0]         dt_mag, den_mag;
  logic [SPAN_W-1:0]        span_mag;
  logic [PROD_W-1:0]        prod;
  duty_mode_e               mode;

  always_comb begin
    pidx_ext = COUNT_W'(primary_index);
    psel     = (pidx_ext < cnt) ? primary_index : '0;
    prim     = (cnt == '0) ? '0 : temp_store[psel[IDX_W-1:0]];
    lo_s     = $signed({3'b000, low_temp_milli});
    hi_s     = $signed({3'b000, high_temp_milli});
    t_s      = (TEMP_W + 1)'(prim);
    if (t_s < lo_s) begin
      t_s = lo_s;
    end else if (t_s > hi_s) begin
      t_s = hi_s;
    end
    dt       = t_s - lo_s;
    den_s    = $signed({1'b0, high_temp_milli}) - $signed({1'b0, low_temp_milli});
    lo_pm    = pct_to_pm(low_duty_pct);
    hi_pm    = pct_to_pm(high_duty_pct);
    span     = $signed({1'b0, hi_pm}) - $signed({1'b0, lo_pm});
    dt_mag   = dt[TEMP_W] ? MAG_W'(-dt) : MAG_W'(dt);
    den_mag  = den_s[THR_W] ? MAG_W'(-den_s) : MAG_W'(den_s);
    span_mag = span[DUTY_W] ? SPAN_W'(-span) : SPAN_W'(span);
    prod     = PROD_W'(dt_mag) * PROD_W'(span_mag);
    if (cnt == '0 || force_max) begin
      mode = MODE_HIGH;
    end else if (high_temp_milli == low_temp_milli) begin
      mode = MODE_LOW;
    end else begin
      mode = MODE_LINEAR;
    end
  end

  // ---- Restoring divider step ----
  logic [MAG_W:0]   shifted;
  logic [MAG_W+1:0] trial;

  always_comb begin
    shifted = {rem, quo[PROD_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      prim_r  <= prim;
      lo_pm_r <= lo_pm;
      hi_pm_r <= hi_pm;
      neg_r   <= dt[TEMP_W] ^ span[DUTY_W] ^ den_s[THR_W];
      mode_r  <= mode;
      den_r   <= den_mag;
      quo     <= prod;
      rem     <= '0;
    end else if (cmd.div_step) begin
      if (!trial[MAG_W+1]) begin
        rem <= trial[MAG_W-1:0];
        quo <= {quo[PROD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[MAG_W-1:0];
        quo <= {quo[PROD_W-2:0], 1'b0};
      end
    end
  end

  // ---- Commit ----
  localparam int SUM_W = PROD_W + 2;
  logic signed [SUM_W-1:0]  lin;
  logic [DUTY_W-1:0]        duty_new, duty_next;
  logic [COUNT_W-1:0]       idx_ext;
  logic                     in_range, good;
  logic signed [OFFSET_W-1:0] off;
  logic signed [TEMP_W:0]   vsum;
  logic signed [TEMP_W-1:0] vsat;
  logic [ERR_W-1:0]         err_next;
  logic                     store_we;

  always_comb begin
    lin = neg_r ? $signed(SUM_W'(lo_pm_r)) - $signed(SUM_W'(quo))
                : $signed(SUM_W'(lo_pm_r)) + $signed(SUM_W'(quo));
    unique case (mode_r)
      MODE_HIGH: duty_new = hi_pm_r;
      MODE_LOW:  duty_new = lo_pm_r;
      default: begin
        if (lin < 0) begin
          duty_new = '0;
        end else if (lin > $signed(SUM_W'(DUTY_MAX))) begin
          duty_new = DUTY_MAX;
        end else begin
          duty_new = lin[DUTY_W-1:0];
        end
      end
    endcase

    idx_ext  = COUNT_W'(idx_r);
    in_range = (idx_ext < cnt);
    good     = ok_r && (reading_r > VALID_FLOOR);
    off      = $signed(offset_table[{idx_r, 4'b0000} +: OFFSET_W]);
    vsum     = (TEMP_W + 1)'(reading_r) + (TEMP_W + 1)'(off);
    if (vsum > (TEMP_W + 1)'(T_MAX)) begin
      vsat = T_MAX;
    end else if (vsum < (TEMP_W + 1)'(T_MIN)) begin
      vsat = T_MIN;
    end else begin
      vsat = vsum[TEMP_W-1:0];
    end

    store_we  = 1'b0;
    err_next  = err_cnt;
    duty_next = duty_reg;
    if (act_r == ACT_TICK) begin
      duty_next = duty_new;
    end else if (in_range) begin
      if (good) begin
        store_we = 1'b1;
      end else if (err_cnt != '1) begin
        err_next = err_cnt + ERR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SENSORS; i++) begin
        temp_store[i] <= '0;
      end
      err_cnt  <= '0;
      duty_reg <= DUTY_RESET;
    end else if (cmd.commit) begin
      if (store_we) begin
        temp_store[idx_r[IDX_W-1:0]] <= vsat;
      end
      err_cnt  <= err_next;
      duty_reg <= duty_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      duty_permille <= duty_next;
      duty_updated  <= act_r;
      primary_milli <= (act_r == ACT_TICK) ? prim_r : '0;
      error_total   <= err_next;
    end
  end

endmodule

`default_nettype wire
